/* rtl/toroidal_delta_distance_bearing_assert.svh */
// assertion macros used by the port-level checker
`ifndef TOROIDAL_DELTA_DISTANCE_BEARING_ASSERT_SVH
`define TOROIDAL_DELTA_DISTANCE_BEARING_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define TDDB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tddb assertion failed");

// clocked assertion that also holds through reset
`define TDDB_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tddb assertion failed");

`endif

/* rtl/tddb_pkg.sv */
// shared constants, register indexes and the cordic angle table
package tddb_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  // cordic datapath
  localparam int CORDIC_STEPS = 32;
  localparam int NORM_TOP     = 59;
  localparam int NORM_PASSES  = 6;
  localparam int XY_W         = 64;
  localparam logic [31:0] HALF_TURN32 = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] turn_angle(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

/* rtl/tddb_if.sv */
// valid/ready channel interfaces for position requests and results
interface tddb_in_if #(parameter int COORD_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] from_x;
  logic [COORD_BITS-1:0] from_y;
  logic [COORD_BITS-1:0] to_x;
  logic [COORD_BITS-1:0] to_y;
  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  input ready);
  modport sink (input valid, input from_x, input from_y, input to_x, input to_y,
                output ready);
endinterface

interface tddb_out_if #(parameter int COORD_BITS = 24, parameter int ANGLE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] delta_x;
  logic signed [COORD_BITS-1:0] delta_y;
  logic [COORD_BITS-1:0]        span;
  logic [ANGLE_BITS-1:0]        bearing;
  logic                         range_error;
  modport source (output valid, output delta_x, output delta_y, output span,
                  output bearing, output range_error, input ready);
  modport sink (input valid, input delta_x, input delta_y, input span,
                input bearing, input range_error, output ready);
endinterface

/* rtl/toroidal_delta_distance_bearing.sv */
// wrap-around delta, distance and bearing pipeline
// throughput: one request per cycle while the output register is not held; set by the
// one-step-per-stage modulo, square root and 32-stage cordic pipelines
// a full pipeline stalls as a whole only when the output register is held
// reset: synchronous active-low, clears valids and sets both periods to all ones
module toroidal_delta_distance_bearing
  import tddb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tddb_in_if.sink               in_ch,
  tddb_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  localparam int CW = COORD_BITS;
  localparam int NB = CW + 1;
  localparam int LB = (CW + 1) / 2;
  localparam int HB = CW - LB;
  localparam int NT = NORM_TOP;

  typedef struct packed {
    logic [CW:0]   absv;
    logic          neg;
    logic [CW-1:0] half;
    logic [CW:0]   per;
    logic [CW:0]   rem;
  } axm_t;

  typedef struct packed {
    axm_t x;
    axm_t y;
    logic bad;
  } mod_t;

  typedef struct packed {
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic [CW-1:0] mx;
    logic [CW-1:0] my;
    logic          bad;
  } del_t;

  typedef struct packed {
    logic [CW-1:0]      dx;
    logic [CW-1:0]      dy;
    logic               bad;
    logic [2*HB-1:0]    xhh;
    logic [HB+LB-1:0]   xhl;
    logic [2*LB-1:0]    xll;
    logic [2*HB-1:0]    yhh;
    logic [HB+LB-1:0]   yhl;
    logic [2*LB-1:0]    yll;
  } mul_t;

  typedef struct packed {
    logic [CW-1:0]   dx;
    logic [CW-1:0]   dy;
    logic            bad;
    logic [2*CW-1:0] sqx;
    logic [2*CW-1:0] sqy;
  } sq_t;

  typedef struct packed {
    logic [CW-1:0]   dx;
    logic [CW-1:0]   dy;
    logic            bad;
    logic [2*CW-1:0] rad;
    logic [CW+1:0]   rem;
    logic [CW-1:0]   root;
  } sqt_t;

  typedef struct packed {
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic          bad;
    logic [CW-1:0] span;
    logic [NT-1:0] mx;
    logic [NT-1:0] my;
  } nrm_t;

  typedef struct packed {
    logic [CW-1:0]          dx;
    logic [CW-1:0]          dy;
    logic                   bad;
    logic [CW-1:0]          span;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [31:0]            z;
  } cor_t;

  // one restoring remainder step at dividend bit pos
  function automatic logic [CW:0] mod_step(input axm_t a, input int unsigned pos);
    logic [CW:0] t;
    t = {a.rem[CW-1:0], a.absv[pos]};
    if (t >= a.per) t = t - a.per;
    return t;
  endfunction

  // remainder to centered delta
  function automatic logic [CW-1:0] fold(input axm_t a);
    logic [CW:0] r;
    logic [CW:0] d;
    r = (a.neg && a.rem != '0) ? a.per - a.rem : a.rem;
    d = r - {1'b0, a.half};
    return d[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mag(input logic [CW-1:0] d);
    return d[CW-1] ? -d : d;
  endfunction

  // one restoring square root step on radicand bit pair pos
  function automatic sqt_t sqrt_step(input sqt_t q, input int unsigned pos);
    sqt_t        o;
    logic [CW+3:0] t;
    logic [CW+3:0] tr;
    o  = q;
    t  = {q.rem, q.rad[pos+1 -: 2]};
    tr = (CW+4)'({q.root, 2'b01});
    if (t >= tr) begin
      t      = t - tr;
      o.root = {q.root[CW-2:0], 1'b1};
    end else begin
      o.root = {q.root[CW-2:0], 1'b0};
    end
    o.rem = t[CW+1:0];
    return o;
  endfunction

  // configuration registers
  logic [CW-1:0] width_r;
  logic [CW-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '1;
      height_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  width_r  <= cfg_data;
        REG_MAP_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline registers
  mod_t mod_nxt [0:NB];
  mod_t mod_r   [0:NB];
  del_t del_nxt, del_r;
  mul_t mul_nxt, mul_r;
  sq_t  sq_nxt, sq_r;
  sqt_t sqt_nxt [0:CW];
  sqt_t sqt_r   [0:CW];
  nrm_t nrm_nxt [0:NORM_PASSES];
  nrm_t nrm_r   [0:NORM_PASSES];
  cor_t cor_nxt [0:CORDIC_STEPS];
  cor_t cor_r   [0:CORDIC_STEPS];

  logic mv_r [0:NB];
  logic dv_r, uv_r, sv_r;
  logic qv_r [0:CW];
  logic nv_r [0:NORM_PASSES];
  logic cv_r [0:CORDIC_STEPS];

  logic en;
  logic load_out;
  logic ov_r, ov_nxt;

  // input stage: periods, biased difference, range check
  logic [CW:0]          per_x, per_y;
  logic [CW-1:0]        half_x, half_y;
  logic signed [CW+1:0] vx, vy, nvx, nvy;

  always_comb begin
    per_x  = (width_r == '0) ? {1'b1, {CW{1'b0}}} : {1'b0, width_r};
    per_y  = (height_r == '0) ? {1'b1, {CW{1'b0}}} : {1'b0, height_r};
    half_x = per_x[CW:1];
    half_y = per_y[CW:1];
    vx  = signed'({2'b00, in_ch.to_x}) - signed'({2'b00, in_ch.from_x})
        + signed'({2'b00, half_x});
    vy  = signed'({2'b00, in_ch.to_y}) - signed'({2'b00, in_ch.from_y})
        + signed'({2'b00, half_y});
    nvx = -vx;
    nvy = -vy;
    mod_nxt[0].x.absv = vx[CW+1] ? nvx[CW:0] : vx[CW:0];
    mod_nxt[0].x.neg  = vx[CW+1];
    mod_nxt[0].x.half = half_x;
    mod_nxt[0].x.per  = per_x;
    mod_nxt[0].x.rem  = '0;
    mod_nxt[0].y.absv = vy[CW+1] ? nvy[CW:0] : vy[CW:0];
    mod_nxt[0].y.neg  = vy[CW+1];
    mod_nxt[0].y.half = half_y;
    mod_nxt[0].y.per  = per_y;
    mod_nxt[0].y.rem  = '0;
    mod_nxt[0].bad = ({1'b0, in_ch.from_x} >= per_x) || ({1'b0, in_ch.to_x} >= per_x)
                  || ({1'b0, in_ch.from_y} >= per_y) || ({1'b0, in_ch.to_y} >= per_y);
  end

  // modulo stages, one dividend bit each
  for (genvar k = 0; k < NB; k++) begin : g_mod
    always_comb begin
      mod_nxt[k+1]       = mod_r[k];
      mod_nxt[k+1].x.rem = mod_step(mod_r[k].x, NB - 1 - k);
      mod_nxt[k+1].y.rem = mod_step(mod_r[k].y, NB - 1 - k);
    end
  end

  // centered deltas and magnitudes
  always_comb begin
    del_nxt.dx  = fold(mod_r[NB].x);
    del_nxt.dy  = fold(mod_r[NB].y);
    del_nxt.mx  = mag(del_nxt.dx);
    del_nxt.my  = mag(del_nxt.dy);
    del_nxt.bad = mod_r[NB].bad;
  end

  // partial products of the squares
  always_comb begin
    mul_nxt.dx  = del_r.dx;
    mul_nxt.dy  = del_r.dy;
    mul_nxt.bad = del_r.bad;
    mul_nxt.xhh = (2*HB)'(del_r.mx[CW-1:LB]) * (2*HB)'(del_r.mx[CW-1:LB]);
    mul_nxt.xhl = (HB+LB)'(del_r.mx[CW-1:LB]) * (HB+LB)'(del_r.mx[LB-1:0]);
    mul_nxt.xll = (2*LB)'(del_r.mx[LB-1:0]) * (2*LB)'(del_r.mx[LB-1:0]);
    mul_nxt.yhh = (2*HB)'(del_r.my[CW-1:LB]) * (2*HB)'(del_r.my[CW-1:LB]);
    mul_nxt.yhl = (HB+LB)'(del_r.my[CW-1:LB]) * (HB+LB)'(del_r.my[LB-1:0]);
    mul_nxt.yll = (2*LB)'(del_r.my[LB-1:0]) * (2*LB)'(del_r.my[LB-1:0]);
  end

  // recombine squares
  always_comb begin
    sq_nxt.dx  = mul_r.dx;
    sq_nxt.dy  = mul_r.dy;
    sq_nxt.bad = mul_r.bad;
    sq_nxt.sqx = ((2*CW)'(mul_r.xhh) << (2*LB)) + ((2*CW)'(mul_r.xhl) << (LB+1))
               + (2*CW)'(mul_r.xll);
    sq_nxt.sqy = ((2*CW)'(mul_r.yhh) << (2*LB)) + ((2*CW)'(mul_r.yhl) << (LB+1))
               + (2*CW)'(mul_r.yll);
  end

  // sum of squares seeds the root
  always_comb begin
    sqt_nxt[0].dx   = sq_r.dx;
    sqt_nxt[0].dy   = sq_r.dy;
    sqt_nxt[0].bad  = sq_r.bad;
    sqt_nxt[0].rad  = sq_r.sqx + sq_r.sqy;
    sqt_nxt[0].rem  = '0;
    sqt_nxt[0].root = '0;
  end

  // square root stages, one root bit each
  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    always_comb begin
      sqt_nxt[k+1] = sqrt_step(sqt_r[k], 2 * (CW - 1 - k));
    end
  end

  // normalizer seed
  always_comb begin
    nrm_nxt[0].dx   = sqt_r[CW].dx;
    nrm_nxt[0].dy   = sqt_r[CW].dy;
    nrm_nxt[0].bad  = sqt_r[CW].bad;
    nrm_nxt[0].span = sqt_r[CW].root;
    nrm_nxt[0].mx   = NT'(mag(sqt_r[CW].dx));
    nrm_nxt[0].my   = NT'(mag(sqt_r[CW].dy));
  end

  // normalize larger magnitude to the top bit, coarse to fine shifts
  for (genvar j = 0; j < NORM_PASSES; j++) begin : g_norm
    localparam int SH = 32 >> j;
    always_comb begin
      nrm_nxt[j+1] = nrm_r[j];
      if (((nrm_r[j].mx | nrm_r[j].my) >> (NT - SH)) == '0) begin
        nrm_nxt[j+1].mx = nrm_r[j].mx << SH;
        nrm_nxt[j+1].my = nrm_r[j].my << SH;
      end
    end
  end

  // fold into the right half plane
  logic signed [XY_W-1:0] ym;

  always_comb begin
    ym = signed'(XY_W'(nrm_r[NORM_PASSES].my));
    cor_nxt[0].dx   = nrm_r[NORM_PASSES].dx;
    cor_nxt[0].dy   = nrm_r[NORM_PASSES].dy;
    cor_nxt[0].bad  = nrm_r[NORM_PASSES].bad;
    cor_nxt[0].span = nrm_r[NORM_PASSES].span;
    cor_nxt[0].x    = signed'(XY_W'(nrm_r[NORM_PASSES].mx));
    cor_nxt[0].y    = (nrm_r[NORM_PASSES].dx[CW-1] ^ nrm_r[NORM_PASSES].dy[CW-1]) ? -ym : ym;
    cor_nxt[0].z    = nrm_r[NORM_PASSES].dx[CW-1] ? HALF_TURN32 : '0;
  end

  // vectoring cordic stages
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_comb begin
      cor_nxt[i+1] = cor_r[i];
      if (!cor_r[i].y[XY_W-1]) begin
        cor_nxt[i+1].x = cor_r[i].x + (cor_r[i].y >>> i);
        cor_nxt[i+1].y = cor_r[i].y - (cor_r[i].x >>> i);
        cor_nxt[i+1].z = cor_r[i].z + turn_angle(5'(i));
      end else begin
        cor_nxt[i+1].x = cor_r[i].x - (cor_r[i].y >>> i);
        cor_nxt[i+1].y = cor_r[i].y + (cor_r[i].x >>> i);
        cor_nxt[i+1].z = cor_r[i].z - turn_angle(5'(i));
      end
    end
  end

  // stall control: the pipeline moves unless the last stage is blocked
  assign load_out    = cv_r[CORDIC_STEPS] && (!ov_r || out_ch.ready);
  assign en          = !cv_r[CORDIC_STEPS] || load_out;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= NB; k++) mod_r[k] <= mod_nxt[k];
      del_r <= del_nxt;
      mul_r <= mul_nxt;
      sq_r  <= sq_nxt;
      for (int k = 0; k <= CW; k++) sqt_r[k] <= sqt_nxt[k];
      for (int k = 0; k <= NORM_PASSES; k++) nrm_r[k] <= nrm_nxt[k];
      for (int k = 0; k <= CORDIC_STEPS; k++) cor_r[k] <= cor_nxt[k];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NB; k++) mv_r[k] <= 1'b0;
      dv_r <= 1'b0;
      uv_r <= 1'b0;
      sv_r <= 1'b0;
      for (int k = 0; k <= CW; k++) qv_r[k] <= 1'b0;
      for (int k = 0; k <= NORM_PASSES; k++) nv_r[k] <= 1'b0;
      for (int k = 0; k <= CORDIC_STEPS; k++) cv_r[k] <= 1'b0;
    end else if (en) begin
      mv_r[0] <= in_ch.valid;
      for (int k = 0; k < NB; k++) mv_r[k+1] <= mv_r[k];
      dv_r <= mv_r[NB];
      uv_r <= dv_r;
      sv_r <= uv_r;
      qv_r[0] <= sv_r;
      for (int k = 0; k < CW; k++) qv_r[k+1] <= qv_r[k];
      nv_r[0] <= qv_r[CW];
      for (int k = 0; k < NORM_PASSES; k++) nv_r[k+1] <= nv_r[k];
      cv_r[0] <= nv_r[NORM_PASSES];
      for (int k = 0; k < CORDIC_STEPS; k++) cv_r[k+1] <= cv_r[k];
    end
  end

  // output register with angle rounding and the flat-delta cases
  logic [31:0]           zr;
  logic [ANGLE_BITS-1:0] bearing_nxt;

  always_comb begin
    zr = cor_r[CORDIC_STEPS].z + (32'd1 << (31 - ANGLE_BITS));
    if (cor_r[CORDIC_STEPS].dy == '0) begin
      bearing_nxt = cor_r[CORDIC_STEPS].dx[CW-1] ? {1'b1, {(ANGLE_BITS-1){1'b0}}} : '0;
    end else begin
      bearing_nxt = zr[31 -: ANGLE_BITS];
    end
    ov_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  logic [CW-1:0]         dx_r, dy_r, span_r;
  logic [ANGLE_BITS-1:0] bearing_r;
  logic                  bad_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      dx_r      <= cor_r[CORDIC_STEPS].dx;
      dy_r      <= cor_r[CORDIC_STEPS].dy;
      span_r    <= cor_r[CORDIC_STEPS].span;
      bearing_r <= bearing_nxt;
      bad_r     <= cor_r[CORDIC_STEPS].bad;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.delta_x     = signed'(dx_r);
  assign out_ch.delta_y     = signed'(dy_r);
  assign out_ch.span        = span_r;
  assign out_ch.bearing     = bearing_r;
  assign out_ch.range_error = bad_r;

endmodule

/* rtl/tddb_checker.sv */
// port-level checker for the wrap-around distance and bearing pipeline
`include "toroidal_delta_distance_bearing_assert.svh"

module tddb_checker #(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_delta_x,
  input logic [COORD_BITS-1:0] out_delta_y,
  input logic [ANGLE_BITS-1:0] out_bearing
);

  localparam logic [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic out_stall;
  logic flat;
  logic west;

  assign out_stall = out_valid && !out_ready;
  assign flat      = out_valid && (out_delta_y == '0);
  assign west      = out_delta_x[COORD_BITS-1];

  // a held result keeps its payload
  `TDDB_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_delta_x) && $stable(out_bearing))
  // input side only stalls behind a blocked result
  `TDDB_ASSERT(a_in_stall, clk, rst_n, !in_ready |-> out_stall)
  // flat deltas point east or west
  `TDDB_ASSERT(a_east, clk, rst_n, flat && !west |-> out_bearing == '0)
  `TDDB_ASSERT(a_west, clk, rst_n, flat && west |-> out_bearing == HALF)
  // reset empties the output
  `TDDB_ASSERT_NR(a_rst, clk, !rst_n |=> !out_valid)

endmodule

bind toroidal_delta_distance_bearing tddb_checker #(
  .COORD_BITS(COORD_BITS),
  .ANGLE_BITS(ANGLE_BITS)
) u_tddb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_delta_x(out_ch.delta_x),
  .out_delta_y(out_ch.delta_y),
  .out_bearing(out_ch.bearing)
);

/* tb/tddb_checker.sv */
// checker: watches the channels, predicts each result and compares it
module tddb_scoreboard
  import tddb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tddb_in_if                   in_ch,
  tddb_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output int                   flagged
);

  typedef struct packed {
    logic signed [23:0] delta_x;
    logic signed [23:0] delta_y;
    logic [23:0]        span;
    logic [15:0]        bearing;
    logic               range_error;
  } geo_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  logic [23:0] width_reg, height_reg;
  geo_t        geo_q[$];

  function automatic longint period_of(input logic [23:0] r);
    return (r == 0) ? 64'd16777216 : longint'({40'd0, r});
  endfunction

  // shortest wrapped delta, target minus origin
  function automatic longint wrap_diff(input logic [23:0] a, input logic [23:0] b,
                                       input longint per);
    longint h, v, r;
    h = per >>> 1;
    v = longint'({40'd0, b}) - longint'({40'd0, a}) + h;
    r = v % per;
    if (r < 0) r += per;
    return r - h;
  endfunction

  function automatic logic [23:0] floor_root(input longint unsigned s);
    longint unsigned root, t;
    root = 0;
    for (int b = 24; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= s) root = t;
    end
    return root[23:0];
  endfunction

  // vectoring cordic on normalized deltas
  function automatic logic [15:0] angle_of(input longint dx, input longint dy);
    longint unsigned mx, my, mm;
    longint x, y, xs, ys;
    logic [31:0] z;
    logic [31:0] zr;
    int sh;
    if (dy == 0) return (dx >= 0) ? 16'd0 : 16'h8000;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    mm = (mx > my) ? mx : my;
    sh = 0;
    while (mm < (64'd1 << 58)) begin
      mm = mm << 1;
      sh++;
    end
    x = (dx < 0) ? -longint'(mx << sh) : longint'(mx << sh);
    y = (dy < 0) ? -longint'(my << sh) : longint'(my << sh);
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN32;
    end
    for (int i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TURN[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TURN[i];
      end
    end
    zr = z + 32'h8000;
    return zr[31:16];
  endfunction

  function automatic geo_t predict_geo(input logic [23:0] fx, input logic [23:0] fy,
                                       input logic [23:0] tx, input logic [23:0] ty);
    geo_t   g;
    longint w, h, dx, dy;
    w = period_of(width_reg);
    h = period_of(height_reg);
    dx = wrap_diff(fx, tx, w);
    dy = wrap_diff(fy, ty, h);
    g.delta_x     = dx[23:0];
    g.delta_y     = dy[23:0];
    g.span        = floor_root(longint'(dx * dx + dy * dy));
    g.bearing     = angle_of(dx, dy);
    g.range_error = ({40'd0, fx} >= w) || ({40'd0, tx} >= w) ||
                    ({40'd0, fy} >= h) || ({40'd0, ty} >= h);
    return g;
  endfunction

  // register copy, prediction on request accept, compare on result accept
  always @(posedge clk) begin
    geo_t exp_g, got;
    if (!rst_n) begin
      width_reg  = 24'hFFFFFF;
      height_reg = 24'hFFFFFF;
      fail_count = 0;
      checked    = 0;
      flagged    = 0;
      geo_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        geo_q.push_back(predict_geo(in_ch.from_x, in_ch.from_y, in_ch.to_x, in_ch.to_y));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.delta_x, out_ch.delta_y, out_ch.span, out_ch.bearing,
                out_ch.range_error};
        if (geo_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          exp_g = geo_q.pop_front();
          checked++;
          if (exp_g.range_error) flagged++;
          if (got !== exp_g) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp dx %0d dy %0d span %h brg %h err %b",
                       exp_g.delta_x, exp_g.delta_y, exp_g.span, exp_g.bearing,
                       exp_g.range_error);
              $display("          got dx %0d dy %0d span %h brg %h err %b",
                       got.delta_x, got.delta_y, got.span, got.bearing,
                       got.range_error);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAP_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_MAP_HEIGHT) height_reg = cfg_data;
      end
    end
    pending = geo_q.size();
  end

endmodule

/* tb/tb_top.sv */
// testbench top: clock, reset, stimulus, receiver stalls and verdict
module tb_top;
  import tddb_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [23:0]          cfg_data;
  logic                 hold_go;
  int                   fail_count, pending, checked, flagged;
  longint               cur_w, cur_h;
  int                   burst_left;

  tddb_in_if  #(24)     in_ch();
  tddb_out_if #(24, 16) out_ch();

  toroidal_delta_distance_bearing dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tddb_scoreboard chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked), .flagged(flagged)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // timeout
  initial begin
    #5000000;
    $display("FAIL toroidal_delta_distance_bearing");
    $finish;
  end

  // receiver: shifting stall pattern plus one long hold-off
  initial begin
    int hold_left, mode, cyc;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    mode = 0;
    cyc = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_go && !hold_done) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  function automatic longint period_of(input logic [23:0] r);
    return (r == 0) ? 64'd16777216 : longint'({40'd0, r});
  endfunction

  function automatic logic [23:0] pick_coord(input longint per);
    case ($urandom_range(0, 9))
      6: return 24'd0;
      7: return 24'(per - 1);
      8: return (per >= 64'd16777215) ? 24'hFFFFFF : 24'($urandom_range(per, 24'hFFFFFF));
      9: return 24'($urandom);
      default: return 24'($urandom_range(0, per - 1));
    endcase
  endfunction

  // offer one request and wait for its accept; gaps come between bursts
  task automatic send_pos(input logic [23:0] fx, input logic [23:0] fy,
                          input logic [23:0] tx, input logic [23:0] ty);
    in_ch.valid  <= 1'b1;
    in_ch.from_x <= fx;
    in_ch.from_y <= fy;
    in_ch.to_x   <= tx;
    in_ch.to_y   <= ty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  // idle the input, let every result arrive, then the pipeline settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_periods(input logic [23:0] w, input logic [23:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    cur_w = period_of(w);
    cur_h = period_of(h);
  endtask

  task automatic random_run(input int n);
    logic [23:0] fx, fy, tx, ty;
    for (int i = 0; i < n; i++) begin
      fx = pick_coord(cur_w);
      fy = pick_coord(cur_h);
      tx = pick_coord(cur_w);
      ty = pick_coord(cur_h);
      case ($urandom_range(0, 9))
        0: ty = fy;
        1: tx = fx;
        2: begin
          tx = fx + 24'($urandom_range(0, 64)) - 24'd32;
          ty = fy + 24'($urandom_range(0, 64)) - 24'd32;
        end
        default: ;
      endcase
      send_pos(fx, fy, tx, ty);
    end
  endtask

  initial begin
    logic [23:0] wl[7], hl[7];
    in_ch.valid  <= 1'b0;
    in_ch.from_x <= '0;
    in_ch.from_y <= '0;
    in_ch.to_x   <= '0;
    in_ch.to_y   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_MAP_WIDTH;
    cfg_data     <= '0;
    hold_go      <= 1'b0;
    rst_n        <= 1'b0;
    burst_left   = 8;
    cur_w = 64'd16777215;
    cur_h = 64'd16777215;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, axis cases, wraps, extremes, out of range
    send_pos(24'd0, 24'd0, 24'd0, 24'd0);
    send_pos(24'd0, 24'd0, 24'd100, 24'd0);
    send_pos(24'd100, 24'd0, 24'd0, 24'd0);
    send_pos(24'd0, 24'd0, 24'd0, 24'd100);
    send_pos(24'd0, 24'd100, 24'd0, 24'd0);
    send_pos(24'd0, 24'd0, 24'hFFFFFE, 24'hFFFFFE);
    send_pos(24'd0, 24'd0, 24'h7FFFFF, 24'h7FFFFF);
    send_pos(24'd0, 24'd0, 24'h800000, 24'h800000);
    send_pos(24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'd0);
    send_pos(24'hFFFFFF, 24'd0, 24'd0, 24'd0);
    send_pos(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
    send_pos(24'd1, 24'd1, 24'd3, 24'd2);
    send_pos(24'h123456, 24'hABCDEF, 24'hFEDCBA, 24'h654321);
    random_run(250);
    drain();

    wl = '{24'd0, 24'd1, 24'd2, 24'd1000, 24'h10000, 24'hFFFFFF, 24'h0};
    hl = '{24'd0, 24'd1, 24'd3, 24'd5000, 24'hFFFFFF, 24'h1, 24'($urandom)};
    wl[6] = 24'($urandom_range(1, 24'hFFFFFF));
    for (int p = 0; p < 7; p++) begin
      set_periods(wl[p], hl[p]);
      if (p == 3) hold_go <= 1'b1;
      random_run(240);
      drain();
    end

    $display("checked %0d results over 8 period settings, %0d with out-of-range coordinates",
             checked, flagged);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS toroidal_delta_distance_bearing");
    end else begin
      $display("FAIL toroidal_delta_distance_bearing");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tddb_pkg.sv
rtl/tddb_if.sv
rtl/toroidal_delta_distance_bearing.sv
rtl/tddb_checker.sv
tb/tddb_checker.sv
tb/tb_top.sv
